>>> hw/rtl/sigmoid_synapse_coupling_unit_macros.svh
// assertion macros for the sigmoid synapse coupling unit
`ifndef SIGMOID_SYNAPSE_COUPLING_UNIT_MACROS_SVH
`define SIGMOID_SYNAPSE_COUPLING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssc: same-cycle check failed");
// next-cycle implication, checked outside reset
`define SSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssc: next-cycle check failed");
`else
`define SSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/ssc_pkg.sv
// shared types and constants of the sigmoid synapse coupling unit
`default_nettype none

package ssc_pkg;

    // field widths and fixed-point constants
    localparam int V_W       = 32;
    localparam int CLASS_W   = 2;
    localparam int SIG_W     = 17;
    localparam int FRAC_W    = 20;
    localparam int U_W       = 21;
    localparam int ARG_LIMIT = 524288;
    localparam int ONE_Q16   = 65536;
    localparam int CFG_IDX_W = 3;

    // neighbor classes
    localparam logic [CLASS_W-1:0] CLASS_EXC = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_INH = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_EXCITATORY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INHIBITORY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSAL_EXCITATORY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSAL_INHIBITORY = 3'd4;

    // datapath step codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INDEX,
        OP_READ,
        OP_INTERP,
        OP_ACCUM,
        OP_PREP,
        OP_MSG,
        OP_MLO,
        OP_MHI,
        OP_CMB,
        OP_SUM,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   term_inh;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic coupled;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ssc_stream_if.sv
// valid/ready stream interfaces for neighbor items and coupling results
`default_nettype none

interface ssc_neighbor_if import ssc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [V_W-1:0]     pre_voltage;
    logic [CLASS_W-1:0]        neighbor_class;
    logic signed [V_W-1:0]     post_voltage;
    logic                      post_coupled;
    logic                      last_neighbor;

    modport source (
        output valid, pre_voltage, neighbor_class, post_voltage, post_coupled,
               last_neighbor,
        input  ready
    );
    modport sink (
        input  valid, pre_voltage, neighbor_class, post_voltage, post_coupled,
               last_neighbor,
        output ready
    );
endinterface

interface ssc_current_if import ssc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [V_W-1:0]     coupling_current;
    logic                      saturated;

    modport source (
        output valid, coupling_current, saturated,
        input  ready
    );
    modport sink (
        input  valid, coupling_current, saturated,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/sigmoid_synapse_coupling_unit.sv
// top level of the sigmoid synapse coupling unit
//
//  channel    dir   handshake      payload
//  neighbor   in    valid/ready    pre_voltage, neighbor_class, post_voltage,
//                                  post_coupled, last_neighbor
//  coupling   out   valid/ready    coupling_current, saturated
//  cfg        in    cfg_write      cfg_index, cfg_data
//
// one item at a time, each through load, index, read, interp and accum; the last
// item of an uncoupled neuron then emits; a coupled one runs prep, msg, mlo, mhi,
// cmb, sum per term, then emits; one shared 33x33 multiplier does all six products.
// asynchronous reset clears config registers, both sums and the output valid.
// a finished result sits in the output register while new items are taken; a
// last item holds in its emit step until the previous result has been transferred.
`default_nettype none

`include "sigmoid_synapse_coupling_unit_macros.svh"

module sigmoid_synapse_coupling_unit import ssc_pkg::*; #(
    parameter int MAX_NEIGHBORS       = 16,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ssc_neighbor_if.sink         neighbor,
    ssc_current_if.source        coupling,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [V_W-1:0]       cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       in_ready;

    // sequencer
    ssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (neighbor.valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // datapath
    ssc_dp #(
        .MAX_NEIGHBORS       (MAX_NEIGHBORS),
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pre_voltage      (neighbor.pre_voltage),
        .neighbor_class   (neighbor.neighbor_class),
        .post_voltage     (neighbor.post_voltage),
        .post_coupled     (neighbor.post_coupled),
        .last_neighbor    (neighbor.last_neighbor),
        .cmd              (dp_cmd),
        .status           (dp_status),
        .out_ready        (coupling.ready),
        .out_valid        (coupling.valid),
        .coupling_current (coupling.coupling_current),
        .saturated        (coupling.saturated)
    );

    assign neighbor.ready = in_ready;

    // a transfer in closes the door until the item has been worked through
    `SSC_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n, neighbor.valid && in_ready, !in_ready)

    // a result is never written over one that is still waiting
    `SSC_ASSERT_IMP(a_emit_slot_free, clk, rst_n, dp_cmd.op == OP_EMIT, !coupling.valid || coupling.ready)

    // a clipped result sits at one of the range limits
    `SSC_ASSERT_IMP(a_clip_value, clk, rst_n, coupling.valid && coupling.saturated, coupling.coupling_current == 32'h7fff_ffff || coupling.coupling_current == 32'h8000_0000)

endmodule

`default_nettype wire

>>> hw/rtl/ssc_sig_rom.sv
// sigmoid lookup table with two registered read ports (entry and its upper neighbor)
`default_nettype none

module ssc_sig_rom import ssc_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rd_en,
    input  logic [$clog2(DEPTH+1)-1:0]         idx,
    output logic [SIG_W-1:0]                   lo_data,
    output logic [SIG_W-1:0]                   hi_data
);

    localparam int IDX_W = $clog2(DEPTH + 1);

    // shift-subtract long division for table construction
    function automatic logic [63:0] sig_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // entry k: 1/(1+exp(-x)) at x = -8 + 16k/depth, unsigned Q1.16
    function automatic logic [SIG_W-1:0] sig_entry(input int k, input int depth);
        int          num_pos;
        int          num_mag;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] r;
        logic [63:0] den;
        logic [63:0] s;
        num_pos = (16 * k >= 8 * depth) ? 1 : 0;
        num_mag = (num_pos != 0) ? (16 * k - 8 * depth) : (8 * depth - 16 * k);
        t = sig_udiv(64'(num_mag) << 27, 64'(depth));
        term = 64'd1 << 31;
        acc = term;
        // taylor series of exp(-t), alternating signs
        for (int i = 1; i <= 14; i++)
        begin
            term = sig_udiv((term * t) >> 31, 64'(i));
            if (i[0])
                acc = acc - term;
            else
                acc = acc + term;
        end
        // raise to the 16th power
        r = acc;
        for (int j = 0; j < 4; j++)
        begin
            r = (r * r) >> 31;
        end
        den = (64'd1 << 31) + r;
        s = sig_udiv((64'd1 << 47) + (den >> 1), den);
        if (num_pos != 0)
            return SIG_W'(s);
        else
            return SIG_W'(64'(ONE_Q16) - s);
    endfunction

    logic [SIG_W-1:0] sig_rom [DEPTH+1];
    logic [IDX_W-1:0] idx_hi;

    // constant entries built at elaboration
    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_entry
        localparam logic [SIG_W-1:0] ENTRY = sig_entry(k, DEPTH);
        assign sig_rom[k] = ENTRY;
    end

    // upper neighbor, held at the last entry at the top end
    assign idx_hi = (idx == IDX_W'(DEPTH)) ? idx : idx + IDX_W'(1);

    // registered reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lo_data <= sig_rom[idx];
            hi_data <= sig_rom[idx_hi];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ssc_ctrl.sv
// step sequencer of the sigmoid synapse coupling unit
`default_nettype none

module ssc_ctrl import ssc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_INTERP,
        ST_ACCUM,
        ST_PREP,
        ST_MSG,
        ST_MLO,
        ST_MHI,
        ST_CMB,
        ST_SUM,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   term_inh_reg, term_inh_next;

    // state and term select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            term_inh_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            term_inh_reg <= term_inh_next;
        end
    end

    // next state and step command
    always_comb
    begin
        state_next    = state_reg;
        term_inh_next = term_inh_reg;
        in_ready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.term_inh  = term_inh_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                cmd.op     = OP_INDEX;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.op     = OP_READ;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.op     = OP_INTERP;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.op = OP_ACCUM;
                if (!status.last)
                    state_next = ST_IDLE;
                else if (status.coupled)
                begin
                    state_next    = ST_PREP;
                    term_inh_next = 1'b0;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = ST_MSG;
            end
            ST_MSG:
            begin
                cmd.op     = OP_MSG;
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                cmd.op     = OP_MLO;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.op     = OP_MHI;
                state_next = ST_CMB;
            end
            ST_CMB:
            begin
                cmd.op     = OP_CMB;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op = OP_SUM;
                if (term_inh_reg)
                    state_next = ST_EMIT;
                else
                begin
                    state_next    = ST_PREP;
                    term_inh_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ssc_dp.sv
// datapath: config registers, sigmoid lookup, accumulators, product and output register
`default_nettype none

module ssc_dp import ssc_pkg::*; #(
    parameter int MAX_NEIGHBORS       = 16,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [V_W-1:0]        cfg_data,
    input  logic signed [V_W-1:0] pre_voltage,
    input  logic [CLASS_W-1:0]    neighbor_class,
    input  logic signed [V_W-1:0] post_voltage,
    input  logic                  post_coupled,
    input  logic                  last_neighbor,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic signed [V_W-1:0] coupling_current,
    output logic                  saturated
);

    localparam int SUM_CAP_I = MAX_NEIGHBORS * ONE_Q16;
    localparam int SUM_W     = $clog2(SUM_CAP_I + 1);
    localparam int IDX_W     = $clog2(SIGMOID_TABLE_DEPTH + 1);
    localparam int POS_W     = U_W + IDX_W;
    localparam int MUL_W     = V_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int M_W       = SUM_W + V_W;
    localparam int P0_W      = 2 * V_W + 1;
    localparam int MAG_W     = SUM_W + 2 * V_W + 1;
    localparam int ACC_W     = MAG_W + 2;
    localparam int Q_W       = ACC_W - V_W;

    localparam logic [SUM_W:0]        SUM_CAP = (SUM_W+1)'(SUM_CAP_I);
    localparam logic signed [V_W:0]   ARG_HI  = (V_W+1)'(ARG_LIMIT);
    localparam logic signed [V_W:0]   ARG_LO  = (V_W+1)'(-ARG_LIMIT);
    localparam logic [ACC_W-1:0]      HALF    = ACC_W'(1) << (V_W - 1);
    localparam logic [V_W-1:0]        Q_MAX   = {1'b0, {(V_W-1){1'b1}}};
    localparam logic [V_W-1:0]        Q_MIN   = {1'b1, {(V_W-1){1'b0}}};

    // configuration
    logic [V_W-1:0] thr_reg, gexc_reg, ginh_reg, rexc_reg, rinh_reg;

    // captured item
    logic [V_W-1:0]     pre_reg, post_reg;
    logic [CLASS_W-1:0] class_reg;
    logic               coupled_reg, last_reg;

    // sigmoid lookup
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [SIG_W-1:0]  lo_data, hi_data;
    logic [SIG_W-1:0]  sig_reg, sig_next;

    // accumulators
    logic [SUM_W-1:0]  exc_sum_reg, inh_sum_reg;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_capped;

    // product
    logic [V_W-1:0]    absg_reg, absg_next;
    logic [V_W:0]      absd_reg, absd_next;
    logic              neg_reg, neg_next;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p, mul_reg;
    logic [M_W-1:0]    m_reg;
    logic [P0_W-1:0]   p0_reg;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W:0]    term_reg, term_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    // output register
    logic              out_valid_reg;
    logic [V_W-1:0]    cur_reg, cur_next;
    logic              sat_reg, sat_next;

    logic signed [V_W:0] arg_x;
    logic [U_W-1:0]      arg_u;
    logic [POS_W-1:0]    pos;
    logic [SIG_W-1:0]    step;
    logic [SIG_W+FRAC_W-1:0] step_frac;
    logic [V_W-1:0]      gain_sel, rev_sel;
    logic signed [V_W:0] diff;
    logic [SUM_W-1:0]    sum_term;
    logic [ACC_W-1:0]    rnd;
    logic [Q_W-1:0]      q;
    logic                fits;

    // clamp argument to +-8.0 and split table position
    always_comb
    begin
        arg_x = $signed({pre_reg[V_W-1], pre_reg}) - $signed({thr_reg[V_W-1], thr_reg});
        if (arg_x < ARG_LO)
            arg_u = '0;
        else if (arg_x > ARG_HI)
            arg_u = U_W'(2 * ARG_LIMIT);
        else
            arg_u = U_W'(arg_x + ARG_HI);
        pos       = POS_W'(arg_u) * POS_W'(SIGMOID_TABLE_DEPTH);
        idx_next  = pos[FRAC_W +: IDX_W];
        frac_next = pos[FRAC_W-1:0];
    end

    ssc_sig_rom #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .rd_en   (cmd.op == OP_READ),
        .idx     (idx_reg),
        .lo_data (lo_data),
        .hi_data (hi_data)
    );

    // linear interpolation between neighboring entries
    always_comb
    begin
        step      = hi_data - lo_data;
        step_frac = (SIG_W+FRAC_W)'(step) * (SIG_W+FRAC_W)'(frac_reg);
        sig_next  = lo_data + step_frac[FRAC_W +: SIG_W];
    end

    // saturating accumulate into the selected sum
    always_comb
    begin
        if (class_reg == CLASS_EXC)
            sum_add = {1'b0, exc_sum_reg} + (SUM_W+1)'(sig_reg);
        else
            sum_add = {1'b0, inh_sum_reg} + (SUM_W+1)'(sig_reg);
        sum_capped = (sum_add > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : sum_add[SUM_W-1:0];
    end

    // term operands: magnitudes and product sign
    always_comb
    begin
        gain_sel  = cmd.term_inh ? ginh_reg : gexc_reg;
        rev_sel   = cmd.term_inh ? rinh_reg : rexc_reg;
        sum_term  = cmd.term_inh ? inh_sum_reg : exc_sum_reg;
        diff      = $signed({rev_sel[V_W-1], rev_sel}) - $signed({post_reg[V_W-1], post_reg});
        absg_next = gain_sel[V_W-1] ? (~gain_sel + V_W'(1)) : gain_sel;
        absd_next = diff[V_W] ? (~diff + (V_W+1)'(1)) : diff;
        neg_next  = gain_sel[V_W-1] ^ diff[V_W];
    end

    // shared unsigned multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MSG:
            begin
                mul_a = MUL_W'(sum_term);
                mul_b = MUL_W'(absg_reg);
            end
            OP_MLO:
            begin
                mul_a = MUL_W'(mul_reg[V_W-1:0]);
                mul_b = absd_reg;
            end
            OP_MHI:
            begin
                mul_a = MUL_W'(m_reg[M_W-1:V_W]);
                mul_b = absd_reg;
            end
            default:
            begin
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // assemble signed term and running total
    always_comb
    begin
        mag       = MAG_W'(p0_reg) + (MAG_W'(mul_reg) << V_W);
        term_next = neg_reg ? (~{1'b0, mag} + (MAG_W+1)'(1)) : {1'b0, mag};
        if (cmd.term_inh)
            acc_next = acc_reg + ACC_W'($signed(term_reg));
        else
            acc_next = ACC_W'($signed(term_reg));
    end

    // round half up to Q16.16 and clip; zero for an uncoupled neuron
    always_comb
    begin
        rnd  = acc_reg + HALF;
        q    = rnd[ACC_W-1:V_W];
        fits = (&q[Q_W-1:V_W-1]) | ~(|q[Q_W-1:V_W-1]);
        if (!coupled_reg)
        begin
            cur_next = '0;
            sat_next = 1'b0;
        end
        else if (fits)
        begin
            cur_next = q[V_W-1:0];
            sat_next = 1'b0;
        end
        else
        begin
            cur_next = q[Q_W-1] ? Q_MIN : Q_MAX;
            sat_next = 1'b1;
        end
    end

    // control state: config, sums, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            gexc_reg      <= '0;
            ginh_reg      <= '0;
            rexc_reg      <= '0;
            rinh_reg      <= '0;
            exc_sum_reg   <= '0;
            inh_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FIRE_THRESHOLD:      thr_reg  <= cfg_data;
                    REG_GAIN_EXCITATORY:     gexc_reg <= cfg_data;
                    REG_GAIN_INHIBITORY:     ginh_reg <= cfg_data;
                    REG_REVERSAL_EXCITATORY: rexc_reg <= cfg_data;
                    REG_REVERSAL_INHIBITORY: rinh_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == OP_ACCUM)
            begin
                case (class_reg)
                    CLASS_EXC: exc_sum_reg <= sum_capped;
                    CLASS_INH: inh_sum_reg <= sum_capped;
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.op == OP_EMIT)
            begin
                exc_sum_reg <= '0;
                inh_sum_reg <= '0;
            end
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, one step at a time
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                pre_reg     <= pre_voltage;
                post_reg    <= post_voltage;
                class_reg   <= neighbor_class;
                coupled_reg <= post_coupled;
                last_reg    <= last_neighbor;
            end
            OP_INDEX:
            begin
                idx_reg  <= idx_next;
                frac_reg <= frac_next;
            end
            OP_INTERP:
            begin
                sig_reg <= sig_next;
            end
            OP_PREP:
            begin
                absg_reg <= absg_next;
                absd_reg <= absd_next;
                neg_reg  <= neg_next;
            end
            OP_MSG:
            begin
                mul_reg <= mul_p;
            end
            OP_MLO:
            begin
                m_reg   <= mul_reg[M_W-1:0];
                mul_reg <= mul_p;
            end
            OP_MHI:
            begin
                p0_reg  <= mul_reg[P0_W-1:0];
                mul_reg <= mul_p;
            end
            OP_CMB:
            begin
                term_reg <= term_next;
            end
            OP_SUM:
            begin
                acc_reg <= acc_next;
            end
            OP_EMIT:
            begin
                cur_reg <= cur_next;
                sat_reg <= sat_next;
            end
            default:
            begin
            end
        endcase
    end

    // status and outputs
    assign status.last     = last_reg;
    assign status.coupled  = coupled_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign coupling_current = cur_reg;
    assign saturated        = sat_reg;

endmodule

`default_nettype wire
